FILE: sv/fqtc_pkg.sv
// Shared types and codes for the tagged FIFO queue.
package fqtc_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = 5;

  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [WORD_W-1:0] data_word;
    logic [WORD_W-1:0] owner_tag;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] popped_data;
    logic [WORD_W-1:0] popped_tag;
    logic [CNT_W-1:0]  tag_matches;
    logic [1:0]        status;
    logic [CNT_W-1:0]  occupancy;
  } result_t;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

FILE: sv/fqtc_cell.sv
// One storage cell of the queue chain: loads a new entry or takes its neighbour's.
module fqtc_cell (
  input  logic                clk,
  input  fqtc_pkg::cell_ctrl_t ctrl,
  input  fqtc_pkg::entry_t    nb,
  input  fqtc_pkg::entry_t    din,
  output fqtc_pkg::entry_t    q
);
  import fqtc_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      q <= din;
    end else if (ctrl.shift) begin
      q <= nb;
    end
  end

endmodule

FILE: sv/fifo_queue_with_tag_count.sv
// Top level of the tagged FIFO queue: cell chain and its controller.
//
// Usage: drive cmd and raise start; the item is taken at a rising edge with
// start high and busy low. Each item gives exactly one result, shown on
// result for a single cycle with done high; the receiver cannot stall it.
// Entries sit in a chain of DEPTH cells, the oldest in cell 0. Push loads
// the cell at the fill position; pop returns cell 0 and shifts the chain
// down by one. For both, and for clear, the result appears the cycle
// after the item is taken and the next item may follow at once.
// Count rotates the whole ring once through the tag compare at cell 0
// with busy high, and its result appears when the rotation ends; the
// rotation leaves the entries in their old order. Reset empties the
// queue and drops any count in progress; cell contents are not cleared
// and are never visible before being written.
module fifo_queue_with_tag_count #(
  parameter int DEPTH = fqtc_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  fqtc_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output fqtc_pkg::result_t result
);
  import fqtc_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int XW = (FW > CNT_W) ? FW : CNT_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_COUNT = 2'b10
  } state_t;

  state_t     state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic [IW-1:0] step, step_next;
  logic [XW-1:0] acc, acc_next;
  logic [XW-1:0] fill_x;
  logic [WORD_W-1:0] tag_q;
  logic       done_next;
  result_t    result_next;
  logic       accept, is_full, is_empty, match, shift, push_ok;

  entry_t     cells [DEPTH];
  cell_ctrl_t ctrl [DEPTH];
  entry_t     new_entry;

  assign accept    = start && !busy;
  assign busy      = (state == S_COUNT);
  assign is_full   = (fill == FW'(DEPTH));
  assign is_empty  = (fill == '0);
  assign match     = (FW'(step) < fill) && (cells[0].tag == tag_q);
  assign new_entry = '{data: cmd.data_word, tag: cmd.owner_tag};
  assign fill_x    = XW'(fill_next);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NB = (i + 1) % DEPTH;
    assign ctrl[i].shift = shift;
    assign ctrl[i].load  = push_ok && (fill == FW'(i));
    fqtc_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl[i]),
      .nb   (cells[NB]),
      .din  (new_entry),
      .q    (cells[i])
    );
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    step_next   = step;
    acc_next    = acc;
    done_next   = 1'b0;
    shift       = 1'b0;
    push_ok     = 1'b0;
    result_next = '0;
    result_next.status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          case (cmd.operation)
            OP_PUSH: begin
              if (is_full) begin
                result_next.status = ST_FULL;
              end else begin
                push_ok   = 1'b1;
                fill_next = fill + 1'b1;
              end
            end
            OP_POP: begin
              if (is_empty) begin
                result_next.status = ST_EMPTY;
              end else begin
                result_next.popped_data = cells[0].data;
                result_next.popped_tag  = cells[0].tag;
                shift     = 1'b1;
                fill_next = fill - 1'b1;
              end
            end
            OP_COUNT: begin
              done_next  = 1'b0;
              state_next = S_COUNT;
              step_next  = '0;
              acc_next   = '0;
            end
            default: begin
              fill_next = '0;
            end
          endcase
        end
      end
      S_COUNT: begin
        shift     = 1'b1;
        acc_next  = acc + XW'(match);
        step_next = step + 1'b1;
        if (step == IW'(DEPTH - 1)) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          result_next.tag_matches = acc_next[CNT_W-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    result_next.occupancy = fill_x[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    step   <= step_next;
    acc    <= acc_next;
    result <= result_next;
    if (accept) begin
      tag_q <= cmd.owner_tag;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.operation == OP_PUSH && !is_full) |=> (fill == $past(fill) + 1'b1))
    else $error("accepted push did not grow the queue");

  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.operation == OP_COUNT) |=> (busy && !done))
    else $error("count did not start its rotation");

  a_count_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("count rotation ended without a result");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> is_full)
    else $error("dropped push reported on a queue that is not full");

endmodule

FILE: tb/fqtc_check.sv
// Checker for the tagged FIFO queue: tracks queue contents, predicts each result, compares.
module fqtc_check
  import fqtc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    done,
  input  result_t result,
  output int      errors,
  output int      pending
);

  logic [WORD_W-1:0] shadow_data [DEPTH];
  logic [WORD_W-1:0] shadow_tag  [DEPTH];
  int shadow_head = 0;
  int shadow_tail = 0;
  int shadow_fill = 0;
  int mismatches  = 0;

  result_t expected_results[$];

  function automatic int step_slot(input int s);
    return (s + 1 >= DEPTH) ? 0 : s + 1;
  endfunction

  // applies one item to the shadow queue and returns the result it should give
  function automatic result_t predict_result(input cmd_t c);
    result_t r;
    int slot;
    r = '0;
    case (c.operation)
      OP_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_data[shadow_tail] = c.data_word;
          shadow_tag[shadow_tail]  = c.owner_tag;
          shadow_tail = step_slot(shadow_tail);
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_data = shadow_data[shadow_head];
          r.popped_tag  = shadow_tag[shadow_head];
          shadow_head = step_slot(shadow_head);
          shadow_fill--;
        end
      end
      OP_COUNT: begin
        slot = shadow_head;
        for (int k = 0; k < shadow_fill; k++) begin
          if (shadow_tag[slot] == c.owner_tag) begin
            r.tag_matches = r.tag_matches + 1'b1;
          end
          slot = step_slot(slot);
        end
      end
      default: begin
        shadow_head = 0;
        shadow_tail = 0;
        shadow_fill = 0;
      end
    endcase
    r.occupancy = CNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want_v,
                             input logic [WORD_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      shadow_head = 0;
      shadow_tail = 0;
      shadow_fill = 0;
      expected_results.delete();
    end else begin
      // a result at this edge belongs to an earlier item, so check before taking a new one
      if (done) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got %0h", $time, result);
        end else begin
          want = expected_results.pop_front();
          check_field("popped_data", want.popped_data, result.popped_data);
          check_field("popped_tag", want.popped_tag, result.popped_tag);
          check_field("tag_matches", WORD_W'(want.tag_matches), WORD_W'(result.tag_matches));
          check_field("status", WORD_W'(want.status), WORD_W'(result.status));
          check_field("occupancy", WORD_W'(want.occupancy), WORD_W'(result.occupancy));
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_result(cmd));
      end
    end
    errors  <= mismatches;
    pending <= expected_results.size();
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the tagged FIFO queue: stimulus, watchdog and verdict.
module tb_top;
  import fqtc_pkg::*;

  localparam int QDEPTH       = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 850;
  localparam int STALL_LIMIT  = 1000;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  int fail_count;
  int outstanding;
  int stall_cycles = 0;
  bit gaps_on      = 1'b1;

  fifo_queue_with_tag_count #(.DEPTH(QDEPTH)) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  fqtc_check #(.DEPTH(QDEPTH)) queue_check (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .done    (done),
    .result  (result),
    .errors  (fail_count),
    .pending (outstanding)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // start stays high between back-to-back items; it only drops for a gap
  task automatic send_item(input logic [1:0] op, input logic [WORD_W-1:0] d,
                           input logic [WORD_W-1:0] t);
    int gap;
    gap = gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd   <= '{operation: op, data_word: d, owner_tag: t};
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // mostly a small pool of tags so that counts find matches
  function automatic logic [WORD_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 8) return WORD_W'($urandom_range(1, 4));
    return $urandom;
  endfunction

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("** fifo_queue_with_tag_count: FAILED **");
      $finish;
    end
  end

  initial begin
    int mode;
    int burst;
    int r;
    int sent;
    logic [1:0] op;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty queue, fill to full with one tag, overflow, wrap, clear
    send_item(OP_POP, '1, '1);
    send_item(OP_COUNT, '1, '0);
    for (int i = 0; i < QDEPTH; i++) begin
      send_item(OP_PUSH, (i == 0) ? '0 : (i == 1) ? '1 : WORD_W'($urandom), '1);
    end
    send_item(OP_PUSH, '1, '0);
    send_item(OP_COUNT, '0, '1);
    send_item(OP_COUNT, '1, '0);
    send_item(OP_POP, '0, '0);
    send_item(OP_PUSH, '0, '0);
    send_item(OP_CLEAR, '1, '1);
    send_item(OP_POP, '0, '0);

    // random bursts: filling, draining or mixed, each with or without gaps
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 2);
      burst   = $urandom_range(4, 40);
      gaps_on = ($urandom_range(0, 2) != 0);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        case (mode)
          0:       op = (r < 70) ? OP_PUSH : (r < 85) ? OP_POP : (r < 98) ? OP_COUNT : OP_CLEAR;
          1:       op = (r < 20) ? OP_PUSH : (r < 80) ? OP_POP : (r < 98) ? OP_COUNT : OP_CLEAR;
          default: op = (r < 40) ? OP_PUSH : (r < 70) ? OP_POP : (r < 99) ? OP_COUNT : OP_CLEAR;
        endcase
        send_item(op, pick_data(), pick_tag());
        sent++;
      end
    end
    start <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (QDEPTH + 4) @(posedge clk);
    // an item still without its result counts as a failure
    if (fail_count == 0 && outstanding == 0) begin
      $display("** fifo_queue_with_tag_count: PASSED **");
    end else begin
      $display("** fifo_queue_with_tag_count: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/fqtc_pkg.sv
sv/fqtc_cell.sv
sv/fifo_queue_with_tag_count.sv
tb/fqtc_check.sv
tb/tb_top.sv
